>>> rtl/core/nps_pkg.sv
// Shared types and constants for the nearest palette entry search block.
// No dependencies; every other file in rtl/core imports this package.

package nps_pkg;

  // Default sizing, handed to the top level parameters
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int MAX_BANDS_DEF   = 4;
  localparam int VALUE_BITS_DEF  = 16;

  // Fixed field widths of the item and result beats
  localparam int OP_W          = 1;
  localparam int ENTRY_IDX_W   = 8;
  localparam int BAND_FIELD_W  = 16;
  localparam int BANDS_USED_W  = 3;
  localparam int IN_BAND_COUNT = 4;
  localparam int MATCH_IDX_W   = 8;
  localparam int DIST_W        = 34;

  // Configuration register widths and bus sizing
  localparam int ENTRY_COUNT_W = 9;
  localparam int BAND_COUNT_W  = 3;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // Item operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Configuration register index (word address)
  typedef enum logic {
    REG_ENTRY_COUNT = 1'b0,
    REG_BAND_COUNT  = 1'b1
  } nps_reg_t;

  // Control from the scan sequencer to the distance unit
  typedef struct packed {
    logic clear;    // start a new entry: zero the accumulator
    logic band_en;  // a band pair is presented this cycle
  } nps_dist_ctl_t;

endpackage

>>> rtl/core/nps_item_if.sv
// Item channel: valid/ready handshake with the write or query payload.
// Depends on nps_pkg for field widths.

interface nps_item_if import nps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [ENTRY_IDX_W-1:0]  entry_index;
  logic [BAND_FIELD_W-1:0] band_value_0;
  logic [BAND_FIELD_W-1:0] band_value_1;
  logic [BAND_FIELD_W-1:0] band_value_2;
  logic [BAND_FIELD_W-1:0] band_value_3;
  logic [BANDS_USED_W-1:0] bands_used;

  modport source (
    output valid, op, entry_index, band_value_0, band_value_1, band_value_2,
           band_value_3, bands_used,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, band_value_0, band_value_1, band_value_2,
           band_value_3, bands_used,
    output ready
  );
endinterface

>>> rtl/core/nps_result_if.sv
// Result channel: valid/ready handshake with the nearest entry answer.
// Depends on nps_pkg for field widths.

interface nps_result_if import nps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MATCH_IDX_W-1:0] match_index;
  logic                   exact_match;
  logic [DIST_W-1:0]      min_distance;
  logic                   query_valid;

  modport source (
    output valid, match_index, exact_match, min_distance, query_valid,
    input  ready
  );

  modport sink (
    input  valid, match_index, exact_match, min_distance, query_valid,
    output ready
  );
endinterface

>>> rtl/core/nps_cfg_regs.sv
// APB-style configuration registers: entry_count and band_count.
// Depends on nps_pkg for register indexes and widths.

module nps_cfg_regs import nps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,
  output logic [ENTRY_COUNT_W-1:0] entry_count,
  output logic [BAND_COUNT_W-1:0]  band_count
);

  nps_reg_t reg_sel;
  logic     wr_en;

  // Registers sit on 32-bit words; decode the word address
  assign reg_sel = nps_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      band_count  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ENTRY_COUNT: entry_count <= pwdata[ENTRY_COUNT_W-1:0];
        REG_BAND_COUNT:  band_count  <= pwdata[BAND_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      REG_ENTRY_COUNT: prdata = CFG_DATA_W'(entry_count);
      REG_BAND_COUNT:  prdata = CFG_DATA_W'(band_count);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/nps_palette_mem.sv
// Palette memory: one row per entry holding all bands, one write and one
// registered read per cycle. Depends on nps_pkg only through the import.

module nps_palette_mem import nps_pkg::*; #(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int WIDTH = MAX_BANDS_DEF * VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Store a whole entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/nps_dist_unit.sv
// Shared distance unit: absolute difference, squarer and accumulator, one
// band per cycle. Depends on nps_pkg for the control struct.

module nps_dist_unit import nps_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  nps_dist_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0]     pal_band,
  input  logic [VALUE_BITS-1:0]     pix_band,
  output logic [2*VALUE_BITS+1:0]   acc
);

  localparam int SQ_W  = 2 * VALUE_BITS;
  localparam int ACC_W = SQ_W + 2;

  logic [VALUE_BITS-1:0] diff;
  logic [SQ_W-1:0]       sq;
  logic                  sq_vld;

  // Absolute band difference
  always_comb begin
    if (pal_band >= pix_band) begin
      diff = pal_band - pix_band;
    end else begin
      diff = pix_band - pal_band;
    end
  end

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= ctl.band_en;
    end
    sq <= SQ_W'(diff) * SQ_W'(diff);
  end

  // Accumulate stage; clear at the start of each entry
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (sq_vld) begin
      acc <= acc + ACC_W'(sq);
    end
  end

endmodule

>>> rtl/core/nearest_palette_entry_search.sv
// Nearest palette entry search, top level with the scan sequencer.
// Write beat: entry stored at the accepting edge, no result.
// Query beat: an invalid query or zero bands goes straight to the result;
// otherwise the scan visits each entry in turn, stopping early on an exact
// hit, paced by the single shared squarer doing one band per cycle. One query at a time.
// Reset: synchronous, clears control and registers; palette is not cleared.

module nearest_palette_entry_search import nps_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int MAX_BANDS   = MAX_BANDS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  nps_item_if.sink              item,
  nps_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ENTRY_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int LANE_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int ROW_W   = MAX_BANDS * VALUE_BITS;
  localparam int ACC_W   = 2 * VALUE_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_BAND,
    S_DRAIN,
    S_CMP,
    S_DONE
  } state_t;

  state_t state;

  logic [ENTRY_COUNT_W-1:0] entry_count;
  logic [BAND_COUNT_W-1:0]  band_count;
  logic [CNT_W-1:0]         num_entries;
  logic [BAND_COUNT_W-1:0]  num_bands;
  logic                     query_ok;

  logic [BAND_FIELD_W-1:0]  in_field [IN_BAND_COUNT];
  logic [VALUE_BITS-1:0]    in_band  [MAX_BANDS];
  logic [ROW_W-1:0]         wr_row;
  logic                     item_acc;
  logic                     mem_we;

  logic [VALUE_BITS-1:0]    q_band [MAX_BANDS];
  logic [BANDS_USED_W-1:0]  used;
  logic [CNT_W-1:0]         ent;
  logic [BANDS_USED_W-1:0]  band;
  logic [ACC_W-1:0]         best;
  logic [ENTRY_W-1:0]       best_idx;
  logic                     q_valid;

  logic [ROW_W-1:0]         rd_row;
  logic [LANE_W-1:0]        lane;
  nps_dist_ctl_t            dist_ctl;
  logic [ACC_W-1:0]         acc;

  nps_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .entry_count (entry_count),
    .band_count  (band_count)
  );

  // Clamp the registers to the built sizes and check the query
  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
      num_entries = CNT_W'(MAX_ENTRIES);
    end else begin
      num_entries = CNT_W'(entry_count);
    end
    if (32'(band_count) > 32'(MAX_BANDS)) begin
      num_bands = BAND_COUNT_W'(MAX_BANDS);
    end else begin
      num_bands = band_count;
    end
    query_ok = (num_entries != '0) && (num_bands != '0)
               && (item.bands_used <= num_bands);
  end

  // Gather input bands; bands beyond the beat's fields are zero
  assign in_field[0] = item.band_value_0;
  assign in_field[1] = item.band_value_1;
  assign in_field[2] = item.band_value_2;
  assign in_field[3] = item.band_value_3;

  for (genvar i = 0; i < MAX_BANDS; i++) begin : g_band
    if (i < IN_BAND_COUNT) begin : g_field
      assign in_band[i] = in_field[i][VALUE_BITS-1:0];
    end else begin : g_zero
      assign in_band[i] = '0;
    end
    assign wr_row[i*VALUE_BITS +: VALUE_BITS] = in_band[i];
  end

  // Take beats only between queries; writes go straight to memory
  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign mem_we     = item_acc && (item.op == OP_WRITE)
                      && (32'(item.entry_index) < 32'(MAX_ENTRIES));

  nps_palette_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ENTRY_W'(item.entry_index)),
    .wdata (wr_row),
    .re    (state == S_READ),
    .raddr (ent[ENTRY_W-1:0]),
    .rdata (rd_row)
  );

  // Feed one band pair per cycle to the shared unit
  assign lane             = band[LANE_W-1:0];
  assign dist_ctl.clear   = (state == S_READ);
  assign dist_ctl.band_en = (state == S_BAND);

  nps_dist_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dist_ctl),
    .pal_band (rd_row[lane*VALUE_BITS +: VALUE_BITS]),
    .pix_band (q_band[lane]),
    .acc      (acc)
  );

  // Scan sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      ent          <= '0;
      band         <= '0;
      used         <= '0;
      best         <= '0;
      best_idx     <= '0;
      q_valid      <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_acc && (item.op == OP_QUERY)) begin
            q_band <= in_band;
            used   <= item.bands_used;
            ent    <= '0;
            q_valid <= query_ok;
            if (!query_ok || (item.bands_used == '0)) begin
              best     <= '0;
              best_idx <= '0;
              state    <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          band  <= '0;
          state <= S_BAND;
        end
        S_BAND: begin
          band <= band + BANDS_USED_W'(1);
          if (band + BANDS_USED_W'(1) == used) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_CMP;
        end
        S_CMP: begin
          // Keep the lowest index on ties; stop on an exact hit
          if ((ent == '0) || (acc < best)) begin
            best     <= acc;
            best_idx <= ent[ENTRY_W-1:0];
          end
          if ((acc == '0) || (ent == num_entries - CNT_W'(1))) begin
            state <= S_DONE;
          end else begin
            ent   <= ent + CNT_W'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          // Hold until the result register is free
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.match_index  <= MATCH_IDX_W'(best_idx);
            result.exact_match  <= q_valid && (best == '0);
            result.min_distance <= DIST_W'(best);
            result.query_valid  <= q_valid;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/tb_nearest_palette_entry_search.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_palette_entry_search: palette writes and
// nearest-entry queries against an in-bench predictor, with register setup over APB.
// Depends on nps_pkg, nps_item_if, nps_result_if and the RTL top level.

module tb_nearest_palette_entry_search;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PRINT_LIMIT     = 40;
  localparam logic [BAND_FIELD_W-1:0] BAND_MAX = '1;

  typedef logic [IN_BAND_COUNT-1:0][BAND_FIELD_W-1:0] pixel_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [ENTRY_IDX_W-1:0]  entry_index;
    pixel_t                  bands;
    logic [BANDS_USED_W-1:0] bands_used;
  } palette_beat_t;

  typedef struct packed {
    logic [MATCH_IDX_W-1:0] match_index;
    logic                   exact_match;
    logic [DIST_W-1:0]      min_distance;
    logic                   query_valid;
  } match_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  nps_item_if   item_bus ();
  nps_result_if result_bus ();

  nearest_palette_entry_search u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the palette and the registers, updated at each accepted beat or register write
  pixel_t                   palette_mirror [MAX_ENTRIES_DEF];
  logic [MAX_ENTRIES_DEF-1:0] entry_written;
  logic [ENTRY_COUNT_W-1:0] cfg_entries;
  logic [BAND_COUNT_W-1:0]  cfg_bands;
  match_t                   pending_matches [$];

  int mismatch_count;
  int cycle_count;
  int burst_left;
  int hold_left;
  int stall_pct;
  int pattern_left;
  bit sender_gaps;
  bit hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[nearest_palette_entry_search] ERROR");
      $finish;
    end
  end

  // Result stall pattern: random duty, redrawn whenever its random-length run ends,
  // plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        pattern_left = $urandom_range(16, 128);
      end
      pattern_left--;
      result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Compare each result beat with the oldest pending answer
  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = {result_bus.match_index, result_bus.exact_match,
             result_bus.min_distance, result_bus.query_valid};
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("result beat with no query pending, index %0d",
                                  got.match_index));
      end else begin
        want = pending_matches.pop_front();
        check_field("match_index", 64'(got.match_index), 64'(want.match_index));
        check_field("exact_match", 64'(got.exact_match), 64'(want.exact_match));
        check_field("min_distance", 64'(got.min_distance), 64'(want.min_distance));
        check_field("query_valid", 64'(got.query_valid), 64'(want.query_valid));
      end
    end
  end

  function automatic int active_entries();
    return (cfg_entries > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cfg_entries);
  endfunction

  function automatic int active_bands();
    return (cfg_bands > MAX_BANDS_DEF) ? MAX_BANDS_DEF : int'(cfg_bands);
  endfunction

  // Scan the mirrored palette: lowest index with the smallest squared distance
  function automatic match_t nearest_entry(input pixel_t px,
                                           input logic [BANDS_USED_W-1:0] used);
    match_t      ans;
    int          ne;
    int          nb;
    logic        ok;
    logic [63:0] best;
    logic [63:0] sum;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] d;
    ne   = active_entries();
    nb   = active_bands();
    ans  = '0;
    best = '0;
    ok   = (ne > 0) && (nb > 0) && (used <= nb);
    if (ok) begin
      for (int e = 0; e < ne; e++) begin
        sum = '0;
        for (int b = 0; b < used; b++) begin
          p = 64'(palette_mirror[e][b]);
          q = 64'(px[b]);
          d = (p >= q) ? p - q : q - p;
          sum += d * d;
        end
        if (e == 0 || sum < best) begin
          best            = sum;
          ans.match_index = MATCH_IDX_W'(e);
        end
        if (sum == 0)
          break;
      end
    end
    ans.exact_match  = ok && (best == 0);
    ans.min_distance = ok ? best[DIST_W-1:0] : '0;
    ans.query_valid  = ok;
    return ans;
  endfunction

  function automatic pixel_t band4(input logic [BAND_FIELD_W-1:0] b0,
                                   input logic [BAND_FIELD_W-1:0] b1,
                                   input logic [BAND_FIELD_W-1:0] b2,
                                   input logic [BAND_FIELD_W-1:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    for (int b = 0; b < IN_BAND_COUNT; b++) begin
      case ($urandom_range(0, 9))
        0:       px[b] = '0;
        1:       px[b] = BAND_MAX;
        default: px[b] = BAND_FIELD_W'($urandom_range(0, 65535));
      endcase
    end
    return px;
  endfunction

  // Offer one beat, hold it until accepted, then update the mirror
  task automatic send_beat(input palette_beat_t beat);
    int gap;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        item_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    item_bus.valid        <= 1'b1;
    item_bus.op           <= beat.op;
    item_bus.entry_index  <= beat.entry_index;
    item_bus.band_value_0 <= beat.bands[0];
    item_bus.band_value_1 <= beat.bands[1];
    item_bus.band_value_2 <= beat.bands[2];
    item_bus.band_value_3 <= beat.bands[3];
    item_bus.bands_used   <= beat.bands_used;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    if (beat.op == OP_WRITE) begin
      palette_mirror[beat.entry_index] = beat.bands;
      entry_written[beat.entry_index]  = 1'b1;
    end else begin
      pending_matches.push_back(nearest_entry(beat.bands, beat.bands_used));
    end
  endtask

  task automatic write_entry(input logic [ENTRY_IDX_W-1:0] idx, input pixel_t px);
    palette_beat_t beat;
    beat.op          = OP_WRITE;
    beat.entry_index = idx;
    beat.bands       = px;
    beat.bands_used  = BANDS_USED_W'($urandom_range(0, 7));
    send_beat(beat);
  endtask

  task automatic query(input pixel_t px, input logic [BANDS_USED_W-1:0] used);
    palette_beat_t beat;
    beat.op          = OP_QUERY;
    beat.entry_index = ENTRY_IDX_W'($urandom_range(0, 255));
    beat.bands       = px;
    beat.bands_used  = used;
    send_beat(beat);
  endtask

  // Drop valid and wait until every pending answer has come back
  task automatic pause_until_idle();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input nps_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (which == REG_ENTRY_COUNT)
      cfg_entries = value[ENTRY_COUNT_W-1:0];
    else
      cfg_bands = value[BAND_COUNT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int entries, input int bands);
    pause_until_idle();
    cfg_write(REG_ENTRY_COUNT, CFG_DATA_W'(entries));
    cfg_write(REG_BAND_COUNT, CFG_DATA_W'(bands));
  endtask

  // Write every entry in range that has never been written
  task automatic fill_palette();
    int ne;
    ne = active_entries();
    for (int e = 0; e < ne; e++)
      if (!entry_written[e])
        write_entry(ENTRY_IDX_W'(e), random_pixel());
  endtask

  // Query mostly near or on a stored entry, sometimes anywhere
  task automatic random_query();
    int                      ne;
    int                      nb;
    int                      kind;
    int                      e;
    pixel_t                  px;
    logic [BANDS_USED_W-1:0] used;
    ne   = active_entries();
    nb   = active_bands();
    px   = random_pixel();
    kind = $urandom_range(0, 9);
    if (ne > 0 && kind < 7) begin
      e  = $urandom_range(0, ne - 1);
      px = palette_mirror[e];
      if (kind >= 4)
        for (int b = 0; b < IN_BAND_COUNT; b++)
          px[b] = px[b] + BAND_FIELD_W'($urandom_range(0, 6)) - BAND_FIELD_W'(3);
    end else if (kind == 7) begin
      for (int b = 0; b < IN_BAND_COUNT; b++)
        px[b] = $urandom_range(0, 1) ? BAND_MAX : '0;
    end
    if ($urandom_range(0, 9) < 8)
      used = BANDS_USED_W'($urandom_range(0, nb));
    else
      used = BANDS_USED_W'($urandom_range(0, 7));
    query(px, used);
  endtask

  task automatic random_write();
    int ne;
    int idx;
    ne = active_entries();
    if (ne > 0 && $urandom_range(0, 3) != 0)
      idx = $urandom_range(0, ne - 1);
    else
      idx = $urandom_range(0, 255);
    write_entry(ENTRY_IDX_W'(idx), random_pixel());
  endtask

  // Empty table: zero entries or zero bands give an invalid answer
  task automatic test_empty_table();
    query(band4(16'd5, 16'd6, 16'd7, 16'd8), 3'd1);
    configure(0, 4);
    query(band4(16'd5, 16'd6, 16'd7, 16'd8), 3'd2);
    configure(4, 0);
    query(band4(16'd0, 16'd0, 16'd0, 16'd0), 3'd0);
  endtask

  // Exact hits, ties between identical entries, zero bands, too many bands
  task automatic test_exact_and_ties();
    configure(4, 4);
    write_entry(8'd0, band4(16'd0, 16'd0, 16'd0, 16'd0));
    write_entry(8'd1, band4(BAND_MAX, BAND_MAX, BAND_MAX, BAND_MAX));
    write_entry(8'd2, band4(16'd1000, 16'd2000, 16'd3000, 16'd4000));
    write_entry(8'd3, band4(16'd1000, 16'd2000, 16'd3000, 16'd4000));
    write_entry(8'd255, band4(16'h8000, 16'h7fff, 16'h5555, 16'haaaa));
    query(band4(BAND_MAX, BAND_MAX, BAND_MAX, BAND_MAX), 3'd4);
    query(band4(16'd0, 16'd0, 16'd0, 16'd0), 3'd4);
    query(band4(16'd1000, 16'd2000, 16'd3000, 16'd4001), 3'd4);
    query(band4(16'd123, 16'd456, 16'd789, 16'd1011), 3'd0);
    query(band4(16'd0, 16'd0, 16'd0, 16'd0), 3'd5);
    query(band4(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 3'd7);
  endtask

  // Register band count against bands_used, including counts above the maximum
  task automatic test_band_limits();
    configure(4, 2);
    query(band4(16'd1000, 16'd2000, 16'd9, 16'd9), 3'd2);
    query(band4(16'd1000, 16'd2000, 16'd9, 16'd9), 3'd3);
    configure(4, 7);
    query(band4(16'd1000, 16'd2000, 16'd3000, 16'd4000), 3'd4);
    query(band4(16'd1000, 16'd2000, 16'd3000, 16'd4000), 3'd5);
  endtask

  // Single entry at zero against an all-ones pixel: largest distance
  task automatic test_largest_distance();
    configure(1, 4);
    query(band4(BAND_MAX, BAND_MAX, BAND_MAX, BAND_MAX), 3'd4);
    query(band4(BAND_MAX, 16'd0, BAND_MAX, 16'd0), 3'd3);
  endtask

  // Hold the result side off while queries keep coming, so the input stalls
  task automatic test_output_backpressure();
    configure(8, 4);
    fill_palette();
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (12) random_query();
    pause_until_idle();
    sender_gaps = 1'b1;
  endtask

  // Random phases over many register settings, with a pause mid-phase
  task automatic test_random_traffic();
    int ne;
    int nb;
    int count;
    for (int p = 0; p < 12; p++) begin
      case (p)
        3: begin
          ne    = 256;
          nb    = 4;
          count = 12;
        end
        7: begin
          ne    = 511;
          nb    = $urandom_range(5, 7);
          count = 12;
        end
        9: begin
          ne    = 0;
          nb    = $urandom_range(0, 7);
          count = 20;
        end
        10: begin
          ne    = $urandom_range(1, 16);
          nb    = 0;
          count = 20;
        end
        default: begin
          ne    = $urandom_range(1, 16);
          nb    = $urandom_range(1, 7);
          count = 12;
        end
      endcase
      sender_gaps = (p % 4 != 1);
      configure(ne, nb);
      fill_palette();
      for (int i = 0; i < count; i++) begin
        if (i == count / 2)
          pause_until_idle();
        if ($urandom_range(0, 3) == 0)
          random_write();
        else
          random_query();
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    item_bus.valid        = 1'b0;
    item_bus.op           = OP_WRITE;
    item_bus.entry_index  = '0;
    item_bus.band_value_0 = '0;
    item_bus.band_value_1 = '0;
    item_bus.band_value_2 = '0;
    item_bus.band_value_3 = '0;
    item_bus.bands_used   = '0;
    result_bus.ready      = 1'b0;
    cfg_entries           = '0;
    cfg_bands             = '0;
    entry_written         = '0;
    sender_gaps           = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_exact_and_ties();
    test_band_limits();
    test_largest_distance();
    test_output_backpressure();
    test_random_traffic();
    pause_until_idle();

    if (mismatch_count == 0)
      $display("[nearest_palette_entry_search] OK");
    else
      $display("[nearest_palette_entry_search] ERROR");
    $finish;
  end

endmodule
